>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL; clk and rst are taken
// from the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants, codes and types of the grid ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam logic [17:0] DIST_MAX   = 18'h3FFFF;
  localparam logic [7:0]  WALL_MIN   = 8'h01;
  localparam logic [7:0]  MARK_LO    = 8'hF0;
  localparam logic [7:0]  MARK_HI    = 8'hF3;

  localparam logic        OP_WRITE   = 1'b0;
  localparam logic        OP_CAST    = 1'b1;

  localparam int          CFG_IDX_W  = 8;
  localparam int          CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 8'd1;
  localparam logic [CFG_DATA_W-1:0] MAP_SIZE_RESET = 7'd64;

  localparam logic [1:0]  FACE_NORTH = 2'd0;
  localparam logic [1:0]  FACE_EAST  = 2'd1;
  localparam logic [1:0]  FACE_SOUTH = 2'd2;
  localparam logic [1:0]  FACE_WEST  = 2'd3;
  localparam logic [1:0]  AXIS_X     = 2'd0;
  localparam logic [1:0]  AXIS_Y     = 2'd1;

  // 2^24 / mag needs 25 quotient bits
  localparam int          RECIP_BITS = 25;

  typedef struct packed {
    logic        start;
    logic [15:0] mag;
  } grc_recip_req_t;

  typedef struct packed {
    logic        done;
    logic [17:0] step;
  } grc_recip_rsp_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIVX  = 9'b000000010,
    S_DIVY  = 9'b000000100,
    S_SIDEX = 9'b000001000,
    S_SIDEY = 9'b000010000,
    S_PREP  = 9'b000100000,
    S_STEP  = 9'b001000000,
    S_READ  = 9'b010000000,
    S_DONE  = 9'b100000000
  } grc_state_t;

  function automatic logic is_wall(input logic [7:0] t);
    return (t >= WALL_MIN) && !(t inside {[MARK_LO:MARK_HI]});
  endfunction

endpackage

>>> hw/rtl/grc_ram.sv
// ----------------------------------------------------------------------------
// grc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/grc_recip.sv
// ----------------------------------------------------------------------------
// grc_recip
// Restoring divider for the step length floor(2^24 / mag), one quotient bit
// per cycle, saturated to DIST_MAX.
// ----------------------------------------------------------------------------
module grc_recip
  import grc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  grc_recip_req_t req,
  output grc_recip_rsp_t rsp
);

  logic                  busy;
  logic [4:0]            cnt;
  logic [16:0]           rem;
  logic [RECIP_BITS-1:0] quo;
  logic [15:0]           mag;

  logic                  bit_in;
  logic [16:0]           rem_sh;
  logic                  ge;
  logic [16:0]           rem_next;
  logic [RECIP_BITS-1:0] quo_next;

  always_comb begin
    // dividend is a single one at the top bit
    bit_in   = (cnt == 5'(RECIP_BITS - 1));
    rem_sh   = {rem[15:0], bit_in};
    ge       = (rem_sh >= {1'b0, mag});
    rem_next = ge ? (rem_sh - {1'b0, mag}) : rem_sh;
    quo_next = {quo[RECIP_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      // pulse done on the last quotient bit
      rsp.done <= busy && !req.start && (cnt == 5'd0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(RECIP_BITS - 1);
        rem  <= '0;
        quo  <= '0;
        mag  <= req.mag;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy     <= 1'b0;
          rsp.step <= (quo_next > RECIP_BITS'(DIST_MAX)) ? DIST_MAX : quo_next[17:0];
        end
      end
    end
  end

endmodule

>>> hw/rtl/grid_ray_dda_caster.sv
// ----------------------------------------------------------------------------
// grid_ray_dda_caster: a tile write lands in the store at its accept; a cast result
// follows two reciprocal divisions (x, then y), the setup of the side distances,
// a step and a tile read per cell walked (a miss ends on a step), then the post.
// One cast in flight. Reset clears control, map sizes go to 64; tiles undefined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_ray_dda_caster
  import grc_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [5:0]            tile_col,
  input  logic [5:0]            tile_row,
  input  logic [7:0]            tile_value,
  input  logic [15:0]           start_x,
  input  logic [15:0]           start_y,
  input  logic signed [15:0]    heading_x,
  input  logic signed [15:0]    heading_y,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [17:0]           distance,
  output logic [1:0]            face,
  output logic                  hit_wall,
  output logic signed [7:0]     cell_col,
  output logic signed [7:0]     cell_row,
  output logic [9:0]            wall_fraction
);

  localparam int AW   = $clog2(MAX_DIM * MAX_DIM);
  // cell coordinates run from -1 to MAX_DIM, and must hold the 6-bit start cell
  localparam int CXW0 = $clog2(MAX_DIM + 1) + 2;
  localparam int CXW  = (CXW0 > 9) ? CXW0 : 9;
  // side distance accumulators: initial step plus one step per cell
  localparam int SDW0 = 19 + $clog2(MAX_DIM + 3);
  localparam int SDW  = (SDW0 > 24) ? SDW0 : 24;

  grc_state_t state;

  logic [CFG_DATA_W-1:0] map_width;
  logic [CFG_DATA_W-1:0] map_height;
  logic [CXW-1:0]        w_lim;
  logic [CXW-1:0]        h_lim;

  logic [15:0]           px, py;
  logic [15:0]           hx, hy;
  logic signed [CXW-1:0] cx, cy;
  logic [17:0]           ddx, ddy;
  logic [SDW-1:0]        sdx, sdy, ray_len;
  logic                  side;
  logic                  hit;
  logic [28:0]           mul_p;

  logic                  accept;
  logic                  neg_x, neg_y;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_SIZE_RESET;
      map_height <= MAP_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- tile store
  // A tile write lands in the memory at the accept edge. Casts are only taken
  // in idle, so a read never overlaps a write still in flight.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign ram_we    = accept && (opcode == OP_WRITE)
                     && (32'(tile_col) < 32'(MAX_DIM)) && (32'(tile_row) < 32'(MAX_DIM));
  assign ram_waddr = AW'(32'(tile_row) * 32'(MAX_DIM) + 32'(tile_col));

  grc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_tiles (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tile_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- reciprocal
  // One divider serves both axes: x starts at accept, y when x finishes.
  grc_recip_req_t recip_req;
  grc_recip_rsp_t recip_rsp;
  logic [15:0]    mag_in_x;
  logic [15:0]    mag_y;

  assign mag_in_x        = heading_x[15] ? (16'd0 - heading_x) : heading_x;
  assign mag_y           = hy[15] ? (16'd0 - hy) : hy;
  assign recip_req.start = (accept && (opcode == OP_CAST))
                           || ((state == S_DIVX) && recip_rsp.done);
  assign recip_req.mag   = (state == S_IDLE) ? mag_in_x : mag_y;

  grc_recip u_recip (
    .clk (clk),
    .rst (rst),
    .req (recip_req),
    .rsp (recip_rsp)
  );

  // ---------------------------------------------------------------- multiplier
  // Shared 24x24 multiplier: initial side distances, then the hit position.
  // Only the low 24 product bits matter for the fraction.
  assign neg_x = hx[15];
  assign neg_y = hy[15];

  logic [10:0] fx, fy;
  logic [23:0] mul_a, mul_b;
  logic [47:0] mul_full;

  always_comb begin
    fx = neg_x ? {1'b0, px[9:0]} : (11'd1024 - {1'b0, px[9:0]});
    fy = neg_y ? {1'b0, py[9:0]} : (11'd1024 - {1'b0, py[9:0]});
    case (state)
      S_SIDEX: begin
        mul_a = 24'(fx);
        mul_b = 24'(ddx);
      end
      S_SIDEY: begin
        mul_a = 24'(fy);
        mul_b = 24'(ddy);
      end
      default: begin
        mul_a = ray_len[23:0];
        mul_b = side ? {{8{hx[15]}}, hx} : {{8{hy[15]}}, hy};
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  // ---------------------------------------------------------------- DDA step
  // Advance along x only when its side distance is strictly smaller.
  logic                  take_x;
  logic signed [CXW-1:0] cx_n, cy_n;
  logic [SDW-1:0]        sdx_next, sdy_next, ray_len_next;
  logic                  outside;

  always_comb begin
    take_x    = (sdx < sdy);
    cx_n      = cx;
    cy_n      = cy;
    sdx_next  = sdx;
    sdy_next  = sdy;
    if (take_x) begin
      ray_len_next = sdx;
      sdx_next     = sdx + SDW'(ddx);
      cx_n         = neg_x ? (cx - CXW'(1)) : (cx + CXW'(1));
    end else begin
      ray_len_next = sdy;
      sdy_next     = sdy + SDW'(ddy);
      cy_n         = neg_y ? (cy - CXW'(1)) : (cy + CXW'(1));
    end
    outside   = cx_n[CXW-1] || cy_n[CXW-1]
                || ($unsigned(cx_n) >= w_lim) || ($unsigned(cy_n) >= h_lim);
    ram_raddr = AW'(32'($unsigned(cy_n)) * 32'(MAX_DIM) + 32'($unsigned(cx_n)));
  end

  // ---------------------------------------------------------------- result
  logic        post;
  logic [23:0] u_sum;
  logic [1:0]  face_hit;

  always_comb begin
    post     = (state == S_DONE) && (!out_valid || out_ready);
    u_sum    = side ? ({px[9:0], 14'd0} + mul_p[23:0])
                    : ({py[9:0], 14'd0} + mul_p[23:0]);
    face_hit = side ? (neg_y ? FACE_SOUTH : FACE_NORTH)
                    : (neg_x ? FACE_EAST  : FACE_WEST);
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one posts in its place
      if (out_valid && out_ready && !post) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_CAST)) begin
            px    <= start_x;
            py    <= start_y;
            hx    <= heading_x;
            hy    <= heading_y;
            cx    <= CXW'(start_x[15:10]);
            cy    <= CXW'(start_y[15:10]);
            w_lim <= (32'(map_width) > 32'(MAX_DIM)) ? CXW'(MAX_DIM) : CXW'(map_width);
            h_lim <= (32'(map_height) > 32'(MAX_DIM)) ? CXW'(MAX_DIM) : CXW'(map_height);
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (recip_rsp.done) begin
            ddx   <= recip_rsp.step;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (recip_rsp.done) begin
            ddy   <= recip_rsp.step;
            state <= S_SIDEX;
          end
        end
        S_SIDEX: begin
          mul_p <= mul_full[28:0];
          state <= S_SIDEY;
        end
        S_SIDEY: begin
          sdx   <= SDW'(mul_p[28:10]);
          mul_p <= mul_full[28:0];
          state <= S_PREP;
        end
        S_PREP: begin
          sdy   <= SDW'(mul_p[28:10]);
          state <= S_STEP;
        end
        S_STEP: begin
          // take one cell; the tile read goes out with the new address
          cx      <= cx_n;
          cy      <= cy_n;
          sdx     <= sdx_next;
          sdy     <= sdy_next;
          ray_len <= ray_len_next;
          side    <= !take_x;
          if (outside) begin
            hit   <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          // tile data is back; start the hit position product in case of a wall
          mul_p <= mul_full[28:0];
          if (is_wall(ram_rdata)) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_STEP;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (post) begin
            out_valid     <= 1'b1;
            distance      <= (ray_len > SDW'(DIST_MAX)) ? DIST_MAX : ray_len[17:0];
            face          <= hit ? face_hit : (side ? AXIS_Y : AXIS_X);
            hit_wall      <= hit;
            cell_col      <= cx[7:0];
            cell_row      <= cy[7:0];
            wall_fraction <= hit ? u_sum[23:14] : 10'd0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  `ASSERT_IMP(a_recip_done_in_div, recip_rsp.done, (state == S_DIVX) || (state == S_DIVY))
  `ASSERT_NXT(a_step_goes_on, state == S_STEP, (state == S_READ) || (state == S_DONE))
  `ASSERT_NXT(a_post_sets_valid, post, out_valid && (state == S_IDLE))
  `ASSERT_IMP(a_miss_no_fraction, out_valid && !hit_wall, wall_fraction == 10'd0)

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid ray caster bench
// Loads every tile that the map sizes below can reach, then casts rays under
// several map sizes and compares every result with a behavioral walk of the
// same tile map. Both sides idle at random; the receiver stalls once at length.
// ----------------------------------------------------------------------------
module tb;
  import grc_pkg::*;

  // one input item as the sender offers it
  typedef struct {
    logic        op;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [7:0]  val;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] hx;
    logic [15:0] hy;
  } ray_item_t;

  // one cast result
  typedef struct {
    logic [17:0] ray_len;
    logic [1:0]  face;
    logic        hit;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [9:0]  frac;
  } ray_hit_t;

  localparam int DIM       = 64;
  localparam int FILL_ROWS = 5;       // full rows loaded from the top
  localparam int FILL_COLS = 9;       // full columns loaded from the left
  localparam int HOLD_AT   = 15000;   // cycle at which the receiver holds off
  localparam int HOLD_LEN  = 3000;
  localparam int CALM_AT   = 35000;   // window without any idling
  localparam int CALM_LEN  = 15000;
  localparam int SETTLE    = 400;     // longer than the slowest cast

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic opcode = 0;
  logic [5:0] tile_col = 0;
  logic [5:0] tile_row = 0;
  logic [7:0] tile_value = 0;
  logic [15:0] start_x = 0;
  logic [15:0] start_y = 0;
  logic signed [15:0] heading_x = 0;
  logic signed [15:0] heading_y = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [17:0] distance;
  logic [1:0] face;
  logic hit_wall;
  logic signed [7:0] cell_col;
  logic signed [7:0] cell_row;
  logic [9:0] wall_fraction;

  grid_ray_dda_caster u_top (.*);

  ray_item_t pending_items[$];
  ray_hit_t  expected_hits[$];
  logic [7:0] tile_map[DIM*DIM];
  int map_w = 64;
  int map_h = 64;
  int errors = 0;
  int casts_done = 0;
  int hits_seen = 0;
  int cyc = 0;
  logic holding;
  logic calm;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // long receiver hold-off and a quiet window, both on the cycle count
  assign holding = (cyc >= HOLD_AT) && (cyc < HOLD_AT + HOLD_LEN);
  assign calm    = (cyc >= CALM_AT) && (cyc < CALM_AT + CALM_LEN);

  function automatic bit wall_code(logic [7:0] t);
    return t != 8'h00 && !(t >= MARK_LO && t <= MARK_HI);
  endfunction

  function automatic longint unsigned recip_step(logic signed [15:0] hd);
    longint unsigned mag;
    longint unsigned q;
    mag = (hd < 0) ? longint'(-int'(hd)) : longint'(hd);
    if (mag == 0) return 262143;
    q = (64'd1 << 24) / mag;
    return (q > 262143) ? 262143 : q;
  endfunction

  // walk the ray over the current tile map and return the crossing
  function automatic ray_hit_t walk_ray(ray_item_t it);
    ray_hit_t r;
    longint unsigned ddx, ddy, sdx, sdy, ray_len, fx, fy;
    longint u;
    int cx, cy, stx, sty, w, h, side;
    w = (map_w > DIM) ? DIM : map_w;
    h = (map_h > DIM) ? DIM : map_h;
    cx = it.sx >> 10;
    cy = it.sy >> 10;
    ddx = recip_step(it.hx);
    ddy = recip_step(it.hy);
    fx = it.sx[9:0];
    fy = it.sy[9:0];
    stx = ($signed(it.hx) < 0) ? -1 : 1;
    sty = ($signed(it.hy) < 0) ? -1 : 1;
    sdx = ((stx < 0 ? fx : 1024 - fx) * ddx) >> 10;
    sdy = ((sty < 0 ? fy : 1024 - fy) * ddy) >> 10;
    ray_len = 0;
    side = 0;
    forever begin
      if (sdx < sdy) begin
        ray_len = sdx; sdx += ddx; cx += stx; side = 0;
      end else begin
        ray_len = sdy; sdy += ddy; cy += sty; side = 1;
      end
      r.ray_len = (ray_len > 262143) ? 18'h3FFFF : ray_len[17:0];
      r.col = cx[7:0];
      r.row = cy[7:0];
      if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
        r.face = side ? AXIS_Y : AXIS_X;
        r.hit = 0;
        r.frac = 0;
        return r;
      end
      if (wall_code(tile_map[cy*DIM + cx])) break;
    end
    // fraction comes from the unsaturated distance
    if (side == 0) begin
      u = (longint'(it.sy) << 14) + longint'(ray_len) * longint'($signed(it.hy));
      r.face = (stx > 0) ? FACE_WEST : FACE_EAST;
    end else begin
      u = (longint'(it.sx) << 14) + longint'(ray_len) * longint'($signed(it.hx));
      r.face = (sty > 0) ? FACE_NORTH : FACE_SOUTH;
    end
    r.hit = 1;
    r.frac = u[23:14];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH cast %0d: %s got %0h expected %0h", casts_done, field, got, want);
    errors++;
  endtask

  // sender: advance to the next pending item once the current one is taken
  always @(posedge clk) begin : drive_items
    ray_item_t it;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
        it = pending_items.pop_front();
        in_valid <= 1;
        opcode <= it.op;
        tile_col <= it.col;
        tile_row <= it.row;
        tile_value <= it.val;
        start_x <= it.sx;
        start_y <= it.sy;
        heading_x <= it.hx;
        heading_y <= it.hy;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // predict on acceptance, check results, and drive the result-side stall
  always @(posedge clk) begin : watch_results
    ray_item_t it;
    ray_hit_t want;
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= !holding && (calm || $urandom_range(99) >= 12);
      if (in_valid && in_ready) begin
        it = '{opcode, tile_col, tile_row, tile_value, start_x, start_y,
               heading_x, heading_y};
        if (it.op == OP_WRITE) tile_map[it.row*DIM + it.col] = it.val;
        else expected_hits.push_back(walk_ray(it));
      end
      if (out_valid && out_ready) begin
        casts_done++;
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_hits.pop_front();
          if (hit_wall) hits_seen++;
          if (distance !== want.ray_len) report_mismatch("distance", distance, want.ray_len);
          if (face !== want.face) report_mismatch("face", face, want.face);
          if (hit_wall !== want.hit) report_mismatch("hit_wall", hit_wall, want.hit);
          if (cell_col !== want.col) report_mismatch("cell_col", cell_col, want.col);
          if (cell_row !== want.row) report_mismatch("cell_row", cell_row, want.row);
          if (wall_fraction !== want.frac)
            report_mismatch("wall_fraction", wall_fraction, want.frac);
        end
      end
    end
  end

  function automatic ray_item_t tile_write(int c, int r, int v);
    ray_item_t it;
    it = '{OP_WRITE, c[5:0], r[5:0], v[7:0], 16'h0, 16'h0, 16'h0, 16'h0};
    it.sx = $urandom; it.hy = $urandom;   // unused operands still toggle
    return it;
  endfunction

  function automatic ray_item_t cast(int x, int y, int hx, int hy);
    ray_item_t it;
    it = '{OP_CAST, 6'($urandom), 6'($urandom), 8'($urandom), x[15:0], y[15:0],
           hx[15:0], hy[15:0]};
    return it;
  endfunction

  function automatic int random_tile();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 78) return MARK_LO + $urandom_range(3);
    if (p < 82) return 8'hFF;
    return $urandom_range(1, 255);
  endfunction

  function automatic int random_heading();
    int p;
    p = $urandom_range(99);
    if (p < 6) return 0;
    if (p < 12) return $urandom_range(1) ? 16384 : -16384;
    if (p < 20) return int'($urandom_range(0, 600)) - 300;
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic drain();
    while (!(pending_items.size() == 0 && !in_valid && expected_hits.size() == 0))
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_map(int w, int h);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= REG_MAP_WIDTH; cfg_data <= w[6:0];
    @(posedge clk);
    cfg_index <= REG_MAP_HEIGHT; cfg_data <= h[6:0];
    @(posedge clk);
    cfg_we <= 0;
    map_w = w; map_h = h;
  endtask

  task automatic random_phase(int n);
    int p, w, h;
    w = (map_w == 0) ? 1 : (map_w > DIM ? DIM : map_w);
    h = (map_h == 0) ? 1 : (map_h > DIM ? DIM : map_h);
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 15)
        pending_items.push_back(tile_write($urandom_range(63), $urandom_range(63),
                                           random_tile()));
      else if (p < 25)
        pending_items.push_back(cast($urandom, $urandom, random_heading(),
                                     random_heading()));
      else
        pending_items.push_back(cast($urandom_range(0, w*1024-1),
                                     $urandom_range(0, h*1024-1),
                                     random_heading(), random_heading()));
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;

    // fill the top rows and left columns; every map below is either at most
    // FILL_COLS wide or at most FILL_ROWS high, so no walk reads an unwritten tile
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++)
        if (r < FILL_ROWS || c < FILL_COLS)
          pending_items.push_back(tile_write(c, r, random_tile()));
    drain();

    // directed casts: extremes of position and heading, zero headings,
    // start markers in the path and rays leaving the map
    set_map(64, 5);
    pending_items.push_back(tile_write(2, 2, MARK_LO));
    pending_items.push_back(tile_write(3, 2, MARK_HI));
    pending_items.push_back(tile_write(4, 2, 8'hFF));
    pending_items.push_back(cast(16'h0800, 16'h0A00, 16384, 0));
    pending_items.push_back(cast(16'h0800, 16'h0A00, 0, 16384));
    pending_items.push_back(cast(16'h0800, 16'h0A00, 0, 0));
    pending_items.push_back(cast(0, 0, -16384, -16384));
    pending_items.push_back(cast(16'hFFFF, 16'hFFFF, 16384, 16384));
    pending_items.push_back(cast(16'h8000, 16'h8000, -16384, 16384));
    pending_items.push_back(cast(16'h8123, 16'h7ABC, 1, -1));
    pending_items.push_back(cast(16'h8123, 16'h7ABC, 16383, -16383));
    pending_items.push_back(cast(16'h0400, 16'h0400, -11585, 11585));
    pending_items.push_back(cast(16'hFC00, 16'h0400, 0, -16384));
    drain();

    // sweep map sizes, including zero and values above the store
    random_phase(150);
    set_map(1, 1);     random_phase(80);
    set_map(0, 17);    random_phase(50);
    set_map(127, 5);   random_phase(150);
    set_map(9, 64);    random_phase(150);
    set_map(64, 1);    random_phase(80);
    set_map(100, 3);   random_phase(80);
    set_map(7, 20);    random_phase(80);

    $display("Covered %0d casts (%0d wall hits) over eight map sizes with random idling",
             casts_done, hits_seen);
    $display("and a %0d-cycle result stall.", HOLD_LEN);
    if (errors == 0) begin
      $display("grid_ray_dda_caster verification clean");
    end else begin
      $display("grid_ray_dda_caster verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding", expected_hits.size());
    $display("grid_ray_dda_caster verification failed");
    $finish;
  end

endmodule
